// ----- design/nfa_pkg.sv -----
// Shared types, constants and sizing helpers for the next-fit ID allocator.
// Used by nfa_scan and next_fit_id_allocator; no dependencies.

package nfa_pkg;

  // Free bitmap word width and the bit-position width inside one word
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);

  // Fixed port field widths
  localparam int ID_FIELD_W  = 12;
  localparam int TAG_FIELD_W = 16;

  // Parameter defaults
  localparam int DEF_ID_COUNT = 4096;
  localparam int DEF_TAG_BITS = 16;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_USE   = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  // Result of one word search
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
  } scan_res_t;

  // Number of bitmap words for a table of n IDs
  function automatic int words_of(int n);
    return (n + WORD_BITS - 1) / WORD_BITS;
  endfunction

  // Word address width, at least one bit
  function automatic int word_aw_of(int n);
    return (words_of(n) > 1) ? $clog2(words_of(n)) : 1;
  endfunction

endpackage

// ----- design/nfa_scan.sv -----
// Word search unit for the next-fit allocator: masks one bitmap word to the
// part of the lap it belongs to and finds its lowest free ID. Uses nfa_pkg.

module nfa_scan import nfa_pkg::*; #(
  parameter int ID_COUNT = DEF_ID_COUNT
) (
  input  logic [word_aw_of(ID_COUNT)-1:0] word,
  input  logic                            phase_b,
  input  logic [$clog2(ID_COUNT)-1:0]     start,
  input  logic [WORD_BITS-1:0]            data,
  output scan_res_t                       res
);

  localparam int WAW = word_aw_of(ID_COUNT);
  localparam int XW  = WAW + BIT_W;

  logic [WORD_BITS-1:0] keep;
  logic [WORD_BITS-1:0] masked;

  // Phase A covers IDs above the start, phase B covers IDs 1 up to just below the start
  always_comb begin
    logic [XW-1:0] s_x;
    logic [XW-1:0] idx;
    s_x = XW'(start);
    for (int b = 0; b < WORD_BITS; b++) begin
      idx = {word, BIT_W'(b)};
      if (phase_b) begin
        keep[b] = (idx < s_x) && (idx != '0);
      end else begin
        keep[b] = (idx > s_x) && (idx <= XW'(ID_COUNT - 1));
      end
    end
  end

  assign masked = data & keep;

  // Lowest set bit wins
  always_comb begin
    res.hit = |masked;
    res.pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (masked[b]) begin
        res.pos = BIT_W'(b);
      end
    end
  end

endmodule

// ----- design/next_fit_id_allocator.sv -----
// Next-fit ID allocator: sequencer, free bitmap and owner store. Uses nfa_pkg, nfa_scan.
// An allocate searches bitmap words of 32 IDs each from the pointer's word; use and free
//   rewrite one word; clear rewrites every word; a stalled result holds the sequencer in ST_FINISH.
// Throughput: one request at a time, as in_stall is high whenever the sequencer is not idle;
//   the single bitmap read port feeds nfa_scan one 32-bit word per cycle.
// Reset: synchronous; a clearing pass over every bitmap word then frees every ID, in_stall high.

module next_fit_id_allocator import nfa_pkg::*; #(
  parameter int ID_COUNT = DEF_ID_COUNT,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             mode,
  input  logic [ID_FIELD_W-1:0]  id,
  input  logic [TAG_FIELD_W-1:0] owner_tag,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ID_FIELD_W-1:0]  new_id,
  output logic                   exhausted,
  output logic                   fatal,
  output logic                   conflict
);

  localparam int WORDS = words_of(ID_COUNT);
  localparam int WAW   = word_aw_of(ID_COUNT);
  localparam int XW    = WAW + BIT_W;
  localparam int IDW   = $clog2(ID_COUNT);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RMW,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  state_t state;

  // Latched request
  mode_t                 mode_q;
  logic [ID_FIELD_W-1:0] id_q;
  logic [TAG_BITS-1:0]   tag_q;

  // Allocation pointer and search sequencer
  logic [IDW-1:0] next_free;
  logic [IDW-1:0] start_q;
  logic [WAW-1:0] start_word;
  logic [WAW-1:0] ia;          // word address being issued
  logic           iph;         // issue phase: 0 above start, 1 wrapped
  logic           iss_on;
  logic [WAW-1:0] ev_word;     // word whose data sits in bm_q
  logic           ev_phase;
  logic           ev_valid;
  scan_res_t      scan;

  // Clearing pass
  logic [WAW-1:0]       sw;
  logic                 sweep_reply;
  logic [WORD_BITS-1:0] sweep_mask;

  // Result staging
  logic [ID_FIELD_W-1:0] res_id;
  logic                  res_exh;
  logic                  res_fatal;
  logic                  res_conf;

  logic server_mode;

  // Free bitmap: one bit per ID, set means free
  logic [WORD_BITS-1:0] bm [WORDS];
  logic [WORD_BITS-1:0] bm_q;
  logic [WAW-1:0]       bm_rd_addr;
  logic                 bm_we;
  logic [WAW-1:0]       bm_wa;
  logic [WORD_BITS-1:0] bm_wd;

  // Owner tags, only compared for entries that are in use
  logic [TAG_BITS-1:0] own [ID_COUNT];
  logic [TAG_BITS-1:0] own_q;
  logic [IDW-1:0]      own_rd_addr;
  logic                own_we;

  logic [BIT_W-1:0]     bit_sel;
  logic                 cur_free;
  logic [WORD_BITS-1:0] rmw_word;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  // Read the request's word and tag straight from the port while idle,
  // so the data is there when the read-modify-write step starts
  assign bm_rd_addr  = (state == ST_IDLE) ? WAW'(id >> BIT_W) : ia;
  assign own_rd_addr = IDW'(id);

  // Read-modify-write of one bitmap word for use and free
  assign bit_sel  = id_q[BIT_W-1:0];
  assign cur_free = bm_q[bit_sel];
  always_comb begin
    rmw_word          = bm_q;
    rmw_word[bit_sel] = (mode_q == MODE_FREE);
  end

  // Every ID that exists starts out free, ID 0 included
  always_comb begin
    logic [XW-1:0] idx;
    for (int b = 0; b < WORD_BITS; b++) begin
      idx           = {sw, BIT_W'(b)};
      sweep_mask[b] = (idx <= XW'(ID_COUNT - 1));
    end
  end

  assign bm_we  = (state == ST_RMW) || (state == ST_SWEEP);
  assign bm_wa  = (state == ST_SWEEP) ? sw : WAW'(id_q >> BIT_W);
  assign bm_wd  = (state == ST_SWEEP) ? sweep_mask : rmw_word;
  assign own_we = (state == ST_RMW) && (mode_q == MODE_USE);

  always_ff @(posedge clk) begin
    bm_q <= bm[bm_rd_addr];
    if (bm_we) begin
      bm[bm_wa] <= bm_wd;
    end
  end

  always_ff @(posedge clk) begin
    own_q <= own[own_rd_addr];
    if (own_we) begin
      own[IDW'(id_q)] <= tag_q;
    end
  end

  // Word search unit for the allocate scan
  nfa_scan #(
    .ID_COUNT (ID_COUNT)
  ) u_scan (
    .word    (ev_word),
    .phase_b (ev_phase),
    .start   (start_q),
    .data    (bm_q),
    .res     (scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sw          <= '0;
      sweep_reply <= 1'b0;
      next_free   <= IDW'(1);
      iss_on      <= 1'b0;
      ev_valid    <= 1'b0;
      out_valid   <= 1'b0;
      server_mode <= 1'b0;
    end else begin
      if (cfg_valid) begin
        server_mode <= cfg_data;
      end
      // Drop a result once the consumer takes it
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            mode_q    <= mode_t'(mode);
            id_q      <= id;
            tag_q     <= TAG_BITS'(owner_tag);
            res_id    <= '0;
            res_exh   <= 1'b0;
            res_fatal <= 1'b0;
            res_conf  <= 1'b0;
            unique case (mode_t'(mode))
              MODE_ALLOC: begin
                // Start the lap at the pointer's own word, above the pointer
                start_q    <= next_free;
                start_word <= WAW'(next_free >> BIT_W);
                ia         <= WAW'(next_free >> BIT_W);
                iph        <= 1'b0;
                iss_on     <= 1'b1;
                ev_valid   <= 1'b0;
                state      <= ST_SCAN;
              end
              MODE_USE, MODE_FREE: begin
                // Ignore IDs past the table
                if (32'(id) < ID_COUNT) begin
                  state <= ST_RMW;
                end else begin
                  state <= ST_FINISH;
                end
              end
              MODE_CLEAR: begin
                sw          <= '0;
                sweep_reply <= 1'b1;
                state       <= ST_SWEEP;
              end
              default: state <= ST_FINISH;
            endcase
          end
        end

        ST_SCAN: begin
          // Issue one word read per cycle; wrap once to word 0, stop at the start word
          ev_word  <= ia;
          ev_phase <= iph;
          ev_valid <= iss_on;
          if (iss_on) begin
            if (!iph && (ia == LAST_WORD)) begin
              ia  <= '0;
              iph <= 1'b1;
            end else if (iph && (ia == start_word)) begin
              iss_on <= 1'b0;
            end else begin
              ia <= ia + WAW'(1);
            end
          end
          // Evaluate the word that came back from the bitmap
          if (ev_valid) begin
            if (scan.hit) begin
              next_free <= IDW'({ev_word, scan.pos});
              res_id    <= ID_FIELD_W'(start_q);
              iss_on    <= 1'b0;
              ev_valid  <= 1'b0;
              state     <= ST_FINISH;
            end else if (ev_phase && (ev_word == start_word)) begin
              // Full lap with nothing free: hold the pointer
              res_exh   <= 1'b1;
              res_fatal <= server_mode;
              iss_on    <= 1'b0;
              ev_valid  <= 1'b0;
              state     <= ST_FINISH;
            end
          end
        end

        ST_RMW: begin
          if (mode_q == MODE_USE) begin
            res_conf <= !cur_free && (own_q != tag_q);
          end
          state <= ST_FINISH;
        end

        ST_SWEEP: begin
          sw <= sw + WAW'(1);
          if (sw == LAST_WORD) begin
            next_free   <= IDW'(1);
            sweep_reply <= 1'b0;
            state       <= sweep_reply ? ST_FINISH : ST_IDLE;
          end
        end

        ST_FINISH: begin
          // Hand the result over once the output register is free
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            new_id    <= res_id;
            exhausted <= res_exh;
            fatal     <= res_fatal;
            conflict  <= res_conf;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // The pointer never names the reserved ID or leaves the table
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (next_free != '0) && (32'(next_free) < ID_COUNT))
    else $error("allocation pointer out of range");

  // An exhausted allocate hands out no ID
  a_exh_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && exhausted |-> (new_id == '0))
    else $error("exhausted result carries an ID");

  // Fatal only accompanies exhaustion, and a conflict never comes with it
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!fatal || exhausted) && !(conflict && exhausted))
    else $error("inconsistent result flags");

  // One request at a time: the sequencer stalls right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for next_fit_id_allocator: directed edge cases, a pointer skip
// across bitmap words, a long receiver hold-off, then phases of random traffic.
// Depends on nfa_pkg and the allocator RTL only.

module tb_top;
  import nfa_pkg::*;

  localparam int ID_COUNT     = DEF_ID_COUNT;
  localparam logic [ID_FIELD_W-1:0] LAST_ID = ID_FIELD_W'(ID_COUNT - 1);
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 160;
  localparam int CYCLE_LIMIT   = 4_000_000;

  typedef struct packed {
    logic [ID_FIELD_W-1:0] new_id;
    logic                  exhausted;
    logic                  fatal;
    logic                  conflict;
  } alloc_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_style_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_data  = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [1:0]             mode      = MODE_ALLOC;
  logic [ID_FIELD_W-1:0]  id        = '0;
  logic [TAG_FIELD_W-1:0] owner_tag = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [ID_FIELD_W-1:0]  new_id;
  logic                   exhausted;
  logic                   fatal;
  logic                   conflict;

  next_fit_id_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .id        (id),
    .owner_tag (owner_tag),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_id    (new_id),
    .exhausted (exhausted),
    .fatal     (fatal),
    .conflict  (conflict)
  );

  // Shadow copy of the ID table, the next-free pointer and the server mode bit.
  bit                     free_map [ID_COUNT];
  logic [TAG_FIELD_W-1:0] tag_map  [ID_COUNT];
  logic [ID_FIELD_W-1:0]  next_ptr;
  bit                     server_on;

  // Results owed by the block, oldest first.
  alloc_result_t pending_results [$];
  // IDs claimed by the random traffic, used to build free and re-claim requests.
  logic [ID_FIELD_W-1:0] held_ids [$];

  int unsigned sent_count      = 0;
  int unsigned alloc_count     = 0;
  int unsigned results_checked = 0;
  int unsigned exhaust_seen    = 0;
  int unsigned fatal_seen      = 0;
  int unsigned conflict_seen   = 0;
  int unsigned mismatch_count  = 0;

  // Sender burst shaping.
  int burst_left = 0;

  // Receiver hold-off handshake between the test sequence and the stall process.
  int hold_asked  = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int seg_left    = 0;
  stall_style_t stall_style = STALL_NONE;

  // Clock: period of 20.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Free every entry, clear every tag and park the pointer at the first ID.
  function automatic void release_all_ids();
    for (int n = 0; n < ID_COUNT; n++) begin
      free_map[n] = 1'b1;
      tag_map[n]  = '0;
    end
    next_ptr = ID_FIELD_W'(1);
  endfunction

  // Apply one request to the shadow table and return the result it must produce.
  function automatic alloc_result_t apply_request(mode_t m, logic [ID_FIELD_W-1:0] req_id,
                                                  logic [TAG_FIELD_W-1:0] tag);
    alloc_result_t r;
    logic [ID_FIELD_W-1:0] scan;
    bit hit;
    r = '0;
    hit = 1'b0;
    case (m)
      MODE_ALLOC: begin
        // Walk one lap at most over IDs 1..LAST_ID; ID 0 is never visited.
        scan = next_ptr;
        for (int step = 0; step < ID_COUNT; step++) begin
          scan = (scan == LAST_ID) ? ID_FIELD_W'(1) : scan + 1'b1;
          if (scan == next_ptr) break;
          if (free_map[scan]) begin
            hit = 1'b1;
            break;
          end
        end
        if (hit) begin
          // Hand out the pointer as it stands, even when that entry is in use.
          r.new_id = next_ptr;
          next_ptr = scan;
        end else begin
          r.exhausted = 1'b1;
          r.fatal     = server_on;
        end
      end
      MODE_USE: begin
        r.conflict      = !free_map[req_id] && (tag_map[req_id] != tag);
        free_map[req_id] = 1'b0;
        tag_map[req_id]  = tag;
      end
      MODE_FREE: begin
        free_map[req_id] = 1'b1;
        tag_map[req_id]  = '0;
      end
      default: release_all_ids();
    endcase
    return r;
  endfunction

  // Offer one request; requests come in bursts of random length, some with a gap before.
  // Valid stays high on return so a following request goes out back to back.
  task automatic send_req(input mode_t m, input logic [ID_FIELD_W-1:0] req_id,
                          input logic [TAG_FIELD_W-1:0] tag);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    mode      <= m;
    id        <= req_id;
    owner_tag <= tag;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(apply_request(m, req_id, tag));
    sent_count++;
    if (m == MODE_ALLOC) alloc_count++;
  endtask

  // Drop valid and hold until every owed result has arrived.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write server_mode; called after wait_for_idle, but the first call runs during the reset clearing pass.
  task automatic write_server_mode(input bit value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    server_on = value;
    cfg_valid <= 1'b0;
  endtask

  // Field extremes, every operation, ID 0, reuse by the same and by another owner,
  // allocate handing out a claimed entry, and clear.
  task automatic test_directed_edges();
    write_server_mode(1'b0);
    send_req(MODE_ALLOC, '0, '0);
    send_req(MODE_ALLOC, LAST_ID, 16'hFFFF);
    send_req(MODE_USE, '0, 16'hFFFF);
    send_req(MODE_USE, '0, 16'h0000);
    send_req(MODE_FREE, '0, 16'h0000);
    send_req(MODE_USE, LAST_ID, 16'hAAAA);
    send_req(MODE_USE, LAST_ID, 16'hAAAA);
    send_req(MODE_USE, LAST_ID, 16'h5555);
    // Claim the entry under the pointer and the one after it, then allocate.
    send_req(MODE_USE, 12'd3, 16'h1234);
    send_req(MODE_USE, 12'd4, 16'h4321);
    send_req(MODE_ALLOC, 12'hFFF, 16'hFFFF);
    send_req(MODE_FREE, 12'd3, 16'hFFFF);
    send_req(MODE_USE, 12'h800, 16'h8000);
    send_req(MODE_USE, 12'h555, 16'h0F0F);
    send_req(MODE_USE, 12'hAAA, 16'hF0F0);
    send_req(MODE_FREE, LAST_ID, 16'h0000);
    send_req(MODE_FREE, 12'd100, 16'h7FFF);
    send_req(MODE_CLEAR, 12'h7FF, 16'hFFFF);
    send_req(MODE_ALLOC, '0, '0);
    send_req(MODE_USE, LAST_ID, 16'h5555);
    wait_for_idle();
  endtask

  // Claim a run spanning three bitmap words ahead of the pointer so allocate has to
  // skip it, then hand out a claimed entry and reopen a hole behind the pointer.
  task automatic test_pointer_skip();
    send_req(MODE_CLEAR, '0, '0);
    for (int i = 2; i <= 70; i++) begin
      send_req(MODE_USE, ID_FIELD_W'(i), TAG_FIELD_W'($urandom_range(0, 16'hFFFF)));
    end
    // Hands out ID 1 and jumps the pointer past the claimed run.
    send_req(MODE_ALLOC, '0, '0);
    send_req(MODE_ALLOC, '0, '0);
    wait_for_idle();
    write_server_mode(1'b1);
    // Claim the entry under the pointer; allocate still hands it out.
    send_req(MODE_USE, 12'd72, 16'hBEEF);
    send_req(MODE_ALLOC, '0, '0);
    send_req(MODE_FREE, 12'd64, '0);
    send_req(MODE_ALLOC, '0, '0);
    send_req(MODE_USE, 12'd70, 16'h0001);
    send_req(MODE_CLEAR, '0, '0);
    wait_for_idle();
    write_server_mode(1'b0);
  endtask

  // Hold the result side off for a long stretch while requests keep coming,
  // so the block backs up into its input.
  task automatic test_stalled_receiver();
    hold_asked <= hold_asked + 1;
    repeat (40) send_req(mode_t'($urandom_range(MODE_ALLOC, MODE_FREE)),
                         ID_FIELD_W'($urandom_range(0, LAST_ID)),
                         TAG_FIELD_W'($urandom_range(0, 16'hFFFF)));
    wait_for_idle();
  endtask

  // Mostly allocate-then-claim flows, frees and re-claims of held IDs, claim runs ahead
  // of the pointer; the rest is plain allocates, noise over all IDs and the odd clear.
  task automatic test_random_traffic();
    int unsigned start_cnt;
    int pick;
    int run;
    int slot;
    logic [ID_FIELD_W-1:0]  claim;
    logic [TAG_FIELD_W-1:0] tag;
    start_cnt = sent_count;
    for (int phase = 0; phase < 4; phase++) begin
      wait_for_idle();
      write_server_mode(~phase[0]);
      while (sent_count - start_cnt < (phase + 1) * RANDOM_ITEMS / 4) begin
        pick = $urandom_range(0, 99);
        tag  = TAG_FIELD_W'($urandom_range(0, 16'hFFFF));
        if (pick < 30) begin
          claim = next_ptr;
          send_req(MODE_ALLOC, ID_FIELD_W'($urandom_range(0, LAST_ID)),
                   TAG_FIELD_W'($urandom_range(0, 16'hFFFF)));
          send_req(MODE_USE, claim, tag);
          held_ids.push_back(claim);
        end else if (pick < 42) begin
          send_req(MODE_ALLOC, ID_FIELD_W'($urandom_range(0, LAST_ID)), tag);
        end else if (pick < 57) begin
          if (held_ids.size() != 0) begin
            slot = $urandom_range(0, held_ids.size() - 1);
            send_req(MODE_FREE, held_ids[slot], tag);
            held_ids.delete(slot);
          end else begin
            send_req(MODE_ALLOC, '0, tag);
          end
        end else if (pick < 68) begin
          // Re-claim a held ID, by its owner half the time, else by a stranger.
          if (held_ids.size() != 0) begin
            slot = $urandom_range(0, held_ids.size() - 1);
            claim = held_ids[slot];
            send_req(MODE_USE, claim, $urandom_range(0, 1) ? tag_map[claim] : tag);
          end else begin
            send_req(MODE_USE, ID_FIELD_W'($urandom_range(0, LAST_ID)), tag);
          end
        end else if (pick < 76) begin
          // Claim a run ahead of the pointer so the next allocate has to skip it.
          run = $urandom_range(1, 40);
          claim = next_ptr;
          for (int k = 1; k <= run; k++) begin
            if (claim + k <= LAST_ID) begin
              send_req(MODE_USE, ID_FIELD_W'(claim + k), tag);
              held_ids.push_back(ID_FIELD_W'(claim + k));
            end
          end
        end else if (pick < 99) begin
          send_req(mode_t'($urandom_range(MODE_USE, MODE_FREE)),
                   ID_FIELD_W'($urandom_range(0, LAST_ID)), tag);
        end else begin
          send_req(MODE_CLEAR, ID_FIELD_W'($urandom_range(0, LAST_ID)), tag);
          held_ids.delete();
        end
      end
    end
  endtask

  // Result side stall: picks a new random style for each segment of random length, and
  // on request holds off without a break for a run set by HOLD_CYCLES.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      seg_left  <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        stall_style <= stall_style_t'($urandom_range(0, 3));
        seg_left    <= $urandom_range(20, 150);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (stall_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  // Compare every accepted result with the oldest owed one.
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: new_id %0d", new_id);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (exhausted === 1'b1) exhaust_seen++;
        if (fatal === 1'b1) fatal_seen++;
        if (conflict === 1'b1) conflict_seen++;
        if (new_id !== want.new_id) begin
          $error("new_id: expected %0d, actual %0d", want.new_id, new_id);
          mismatch_count++;
        end
        if (exhausted !== want.exhausted) begin
          $error("exhausted: expected %0b, actual %0b", want.exhausted, exhausted);
          mismatch_count++;
        end
        if (fatal !== want.fatal) begin
          $error("fatal: expected %0b, actual %0b", want.fatal, fatal);
          mismatch_count++;
        end
        if (conflict !== want.conflict) begin
          $error("conflict: expected %0b, actual %0b", want.conflict, conflict);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycle_cnt,
             pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Main sequence: reset, run each test in turn, settle, report.
  initial begin
    release_all_ids();
    server_on = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_pointer_skip();
    test_stalled_receiver();
    test_random_traffic();
    wait_for_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d allocate), checked %0d results.", sent_count,
             alloc_count, results_checked);
    $display("Saw %0d exhausted, %0d fatal, %0d conflicts; %0d mismatches.", exhaust_seen,
             fatal_seen, conflict_seen, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/nfa_pkg.sv
design/nfa_scan.sv
design/next_fit_id_allocator.sv
test/tb_top.sv
